FILE: rtl/mihs_pkg.sv
// ============================================================================
// mihs_pkg
// Shared types and constants for the merge/insertion hybrid sorter.
// ============================================================================
package mihs_pkg;

    // Width of one sorted element.
    localparam int DATA_W = 32;

    // Default capacity of the element store.
    localparam int DEPTH_DEF = 64;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,    // collecting input transfers
        ST_BLK,     // set up the run pair of the next merge block
        ST_WAIT,    // memory read in flight for the run heads
        ST_CMP,     // compare the run heads and write one element
        ST_RD,      // memory read in flight for the next result
        ST_OUT      // result held on the output until taken
    } state_t;

endpackage

FILE: rtl/merge_insertion_hybrid_sort.sv
// ============================================================================
// merge_insertion_hybrid_sort
// Collects a set of signed values and returns them in ascending order.
// ============================================================================
// Values arrive on the s_ stream, one per transfer; s_tlast closes the set.
// Up to DEPTH values are kept; later values of the set are discarded and
// the final result reports this in m_tuser.
// After the closing transfer the block sorts with bottom-up merge passes that
// alternate between the element memory and the scratch memory. Each merged
// element takes a memory read, then a compare and write, and each run pair
// an extra setup step before its first read. The single write port and the
// registered read ports of each memory force these steps to run in turn.
// Results then leave on the m_ stream in ascending signed order, each read
// from memory before it is offered; m_tlast marks the final one. A stalled
// receiver simply holds the current result. No new set is taken until the
// final result has been transferred. Reset empties the store and clears the
// drop flag; the memories are not cleared.
// ============================================================================
module merge_insertion_hybrid_sort #(
    parameter int DEPTH = mihs_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mihs_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                        s_tlast,   // last
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mihs_pkg::DATA_W-1:0] m_tdata,   // [31:0] value_res
    output logic                        m_tlast,   // last_res
    output logic                        m_tuser    // [0] dropped
);
    import mihs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              a_we;
    logic [AW-1:0]     a_waddr;
    logic [DATA_W-1:0] a_wdata;
    logic [DATA_W-1:0] a_rdata0;
    logic [DATA_W-1:0] a_rdata1;
    logic              b_we;
    logic [AW-1:0]     b_waddr;
    logic [DATA_W-1:0] b_wdata;
    logic [DATA_W-1:0] b_rdata0;
    logic [DATA_W-1:0] b_rdata1;
    logic [AW-1:0]     raddr0;
    logic [AW-1:0]     raddr1;

    mihs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .a_we     (a_we),
        .a_waddr  (a_waddr),
        .a_wdata  (a_wdata),
        .a_rdata0 (a_rdata0),
        .a_rdata1 (a_rdata1),
        .b_we     (b_we),
        .b_waddr  (b_waddr),
        .b_wdata  (b_wdata),
        .b_rdata0 (b_rdata0),
        .b_rdata1 (b_rdata1),
        .raddr0   (raddr0),
        .raddr1   (raddr1)
    );

    // Element memory: loaded from the input and used by every even pass.
    mihs_ram #(
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .clk    (clk),
        .we     (a_we),
        .waddr  (a_waddr),
        .wdata  (a_wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (a_rdata0),
        .rdata1 (a_rdata1)
    );

    // Scratch memory: target of every even pass.
    mihs_ram #(
        .DEPTH (DEPTH)
    ) u_scratch_ram (
        .clk    (clk),
        .we     (b_we),
        .waddr  (b_waddr),
        .wdata  (b_wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (b_rdata0),
        .rdata1 (b_rdata1)
    );

endmodule

FILE: rtl/mihs_ram.sv
// ============================================================================
// mihs_ram
// Synchronous memory with one write port and two registered read ports.
// ============================================================================
module mihs_ram #(
    parameter int DEPTH = mihs_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [mihs_pkg::DATA_W-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]    raddr0,
    input  logic [$clog2(DEPTH)-1:0]    raddr1,
    output logic [mihs_pkg::DATA_W-1:0] rdata0,
    output logic [mihs_pkg::DATA_W-1:0] rdata1
);
    import mihs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

FILE: rtl/mihs_ctrl.sv
// ============================================================================
// mihs_ctrl
// Load, bottom-up merge and emission sequencer. The merge passes ping-pong
// between the element memory and the scratch memory.
// ============================================================================
module mihs_ctrl #(
    parameter int DEPTH = mihs_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mihs_pkg::DATA_W-1:0] s_tdata,
    input  logic                        s_tlast,
    // output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mihs_pkg::DATA_W-1:0] m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser,
    // element memory
    output logic                        a_we,
    output logic [$clog2(DEPTH)-1:0]    a_waddr,
    output logic [mihs_pkg::DATA_W-1:0] a_wdata,
    input  logic [mihs_pkg::DATA_W-1:0] a_rdata0,
    input  logic [mihs_pkg::DATA_W-1:0] a_rdata1,
    // scratch memory
    output logic                        b_we,
    output logic [$clog2(DEPTH)-1:0]    b_waddr,
    output logic [mihs_pkg::DATA_W-1:0] b_wdata,
    input  logic [mihs_pkg::DATA_W-1:0] b_rdata0,
    input  logic [mihs_pkg::DATA_W-1:0] b_rdata1,
    // shared read addresses
    output logic [$clog2(DEPTH)-1:0]    raddr0,
    output logic [$clog2(DEPTH)-1:0]    raddr1
);
    import mihs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + 1;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    state_t state_reg, state_next;

    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [WW-1:0] w_reg, w_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] e_reg, e_next;
    logic          src_reg, src_next;   // 0: runs in element memory

    logic              in_xfer;
    logic              full;
    logic [CW-1:0]     fill_inc;
    logic [WW:0]       lo_ext;
    logic [WW:0]       n_ext;
    logic [WW:0]       sum_mid;
    logic [WW:0]       sum_hi;
    logic [WW-1:0]     w_dbl;
    logic [DATA_W-1:0] rd_i;
    logic [DATA_W-1:0] rd_j;
    logic              take_i;
    logic [DATA_W-1:0] merge_data;
    logic [CW-1:0]     k_inc;
    logic [CW-1:0]     e_inc;
    logic              out_last;
    logic              merge_wr;

    assign in_xfer  = s_tvalid && s_tready;
    assign full     = (fill_reg == FULL);
    assign fill_inc = fill_reg + CW'(1);

    assign lo_ext  = (WW + 1)'(lo_reg);
    assign n_ext   = (WW + 1)'(fill_reg);
    assign sum_mid = lo_ext + (WW + 1)'(w_reg);
    assign sum_hi  = lo_ext + {w_reg, 1'b0};
    assign w_dbl   = {w_reg[WW-2:0], 1'b0};

    assign rd_i = src_reg ? b_rdata0 : a_rdata0;
    assign rd_j = src_reg ? b_rdata1 : a_rdata1;

    // The left run wins ties, which keeps equal values in arrival order.
    assign take_i = (i_reg < mid_reg)
                 && ((j_reg >= hi_reg) || ($signed(rd_i) <= $signed(rd_j)));
    assign merge_data = take_i ? rd_i : rd_j;
    assign k_inc      = k_reg + CW'(1);
    assign e_inc      = e_reg + CW'(1);
    assign out_last   = (e_inc == fill_reg);

    // Next state and datapath registers.
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        w_next     = w_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        src_next   = src_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                    if (s_tlast)
                    begin
                        w_next   = WW'(1);
                        lo_next  = '0;
                        src_next = 1'b0;
                        e_next   = '0;
                        // A set of one element is already in order.
                        if ((full ? fill_reg : fill_inc) == CW'(1))
                        begin
                            state_next = ST_RD;
                        end
                        else
                        begin
                            state_next = ST_BLK;
                        end
                    end
                end
            end
            ST_BLK:
            begin
                mid_next   = (sum_mid >= n_ext) ? fill_reg : sum_mid[CW-1:0];
                hi_next    = (sum_hi >= n_ext) ? fill_reg : sum_hi[CW-1:0];
                i_next     = lo_reg;
                j_next     = (sum_mid >= n_ext) ? fill_reg : sum_mid[CW-1:0];
                k_next     = lo_reg;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                k_next = k_inc;
                if (take_i)
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
                if (k_inc == hi_reg)
                begin
                    if (sum_hi >= n_ext)
                    begin
                        // Pass finished: the merged runs now live in the other memory.
                        src_next = !src_reg;
                        w_next   = w_dbl;
                        lo_next  = '0;
                        e_next   = '0;
                        if (w_dbl >= WW'(fill_reg))
                        begin
                            state_next = ST_RD;
                        end
                        else
                        begin
                            state_next = ST_BLK;
                        end
                    end
                    else
                    begin
                        lo_next    = sum_hi[CW-1:0];
                        state_next = ST_BLK;
                    end
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_RD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (out_last)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        e_next     = e_inc;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Handshakes and memory controls.
    always_comb
    begin
        s_tready = (state_reg == ST_LOAD);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = rd_i;
        m_tlast  = out_last;
        m_tuser  = out_last && ovf_reg;

        merge_wr = (state_reg == ST_CMP);

        a_we    = (in_xfer && !full) || (merge_wr && src_reg);
        a_waddr = merge_wr ? k_reg[AW-1:0] : fill_reg[AW-1:0];
        a_wdata = merge_wr ? merge_data : s_tdata;

        b_we    = merge_wr && !src_reg;
        b_waddr = k_reg[AW-1:0];
        b_wdata = merge_data;

        if ((state_reg == ST_RD) || (state_reg == ST_OUT))
        begin
            raddr0 = e_reg[AW-1:0];
        end
        else
        begin
            raddr0 = i_reg[AW-1:0];
        end
        raddr1 = j_reg[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            src_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            src_reg   <= src_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        lo_reg  <= lo_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        e_reg   <= e_next;
    end

endmodule

FILE: tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the merge/insertion hybrid sorter.
// ============================================================================
// Sets of signed values go in on the s_ stream and are mirrored into a local
// store. When a set closes, the bench sorts its copy and queues the sorted
// results. Each m_ transfer is checked against the oldest queued result. The
// tests cover the value extremes, duplicates, single-value sets and overflow.
// They also cover a long receiver hold-off and random sets with random gaps
// and stalls on both sides.
// ============================================================================
module testbench;

    import mihs_pkg::*;

    localparam int SET_CAPACITY = DEPTH_DEF;
    localparam int STALL_LIMIT  = 5000;

    typedef logic signed [DATA_W-1:0] sample_t;

    typedef struct packed {
        sample_t value;
        logic    closing;
        logic    dropped;
    } sorted_item_t;

    localparam sample_t MOST_NEG = 32'h8000_0000;
    localparam sample_t MOST_POS = 32'h7fff_ffff;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;    // [31:0] value
    logic              s_tlast  = 1'b0;  // last
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;          // [31:0] value_res
    logic              m_tlast;          // last_res
    logic              m_tuser;          // [0] dropped

    // Local copy of the set being loaded and the results still owed.
    sample_t      held_values[$];
    logic         held_overflow = 1'b0;
    sorted_item_t pending_sorted[$];

    int mismatches = 0;
    int hold_len   = 0;
    bit no_idle    = 1'b0;
    int idle_count = 0;

    merge_insertion_hybrid_sort dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Mirrors one accepted value; a closing value releases the sorted set.
    function automatic void absorb_value(input sample_t v, input logic closes);
        sample_t      key;
        int           j;
        sorted_item_t item;
        if (held_values.size() < SET_CAPACITY)
            held_values = {held_values, v};
        else
            held_overflow = 1'b1;
        if (closes)
        begin
            for (int i = 1; i < held_values.size(); i++)
            begin
                key = held_values[i];
                j = i;
                while (j > 0 && held_values[j-1] > key)
                begin
                    held_values[j] = held_values[j-1];
                    j--;
                end
                held_values[j] = key;
            end
            for (int i = 0; i < held_values.size(); i++)
            begin
                item.value   = held_values[i];
                item.closing = (i == held_values.size() - 1);
                item.dropped = item.closing ? held_overflow : 1'b0;
                pending_sorted = {pending_sorted, item};
            end
            held_values.delete();
            held_overflow = 1'b0;
        end
    endfunction

    function automatic sample_t pick_value(input bit narrow);
        sample_t v;
        if (narrow)
            v = int'($urandom_range(0, 3)) - 1;
        else
        begin
            case ($urandom_range(0, 7))
                0: v = MOST_NEG;
                1: v = MOST_POS;
                2: v = int'($urandom_range(0, 8)) - 4;
                default: v = $urandom;
            endcase
        end
        return v;
    endfunction

    task automatic offer_value(input sample_t v, input logic closes);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= closes;
        do
            @(posedge clk);
        while (!s_tready);
        absorb_value(v, closes);
    endtask

    // Stops offering and waits until every queued result has come out.
    task automatic wait_all_sorted();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_sorted.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        sample_t vals[7];
        vals = '{MOST_POS, MOST_NEG, 0, -1, 1, MOST_NEG, MOST_POS};
        for (int i = 0; i < 7; i++)
            offer_value(vals[i], i == 6);
    endtask

    task automatic test_single();
        offer_value(pick_value(1'b0), 1'b1);
    endtask

    task automatic test_equal_values();
        sample_t same;
        same = $urandom;
        for (int i = 0; i < 5; i++)
            offer_value(same, 1'b0);
        offer_value(~same, 1'b1);
    endtask

    // The store fills at the 64th value, so the last two are discarded,
    // including the one that closes the set.
    task automatic test_overflow();
        for (int i = 0; i < SET_CAPACITY + 2; i++)
            offer_value(pick_value(1'b0), i == SET_CAPACITY + 1);
    endtask

    task automatic test_backpressure();
        hold_len = 300;
        for (int i = 0; i < 10; i++)
            offer_value(pick_value(1'b0), i == 9);
        for (int i = 0; i < 8; i++)
            offer_value(pick_value(1'b0), i == 7);
    endtask

    task automatic test_random(input int n_items);
        int  sent;
        int  set_len;
        bit  narrow;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
                set_len = $urandom_range(60, 70);
            else
                set_len = $urandom_range(1, 14);
            // The final set is cut short so the item count stays as asked.
            if (set_len > n_items - sent)
                set_len = n_items - sent;
            narrow = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_len; i++)
                offer_value(pick_value(narrow), i == set_len - 1);
            sent += set_len;
        end
    endtask

    // Receiver: random stall bursts, plus a long hold-off when requested.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        sorted_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_sorted.size() == 0)
            begin
                $error("unexpected result transfer: value_res %0d", $signed(m_tdata));
                mismatches++;
            end
            else
            begin
                want = pending_sorted.pop_front();
                if (m_tdata !== want.value)
                begin
                    $error("value_res: expected %0d, got %0d", want.value, $signed(m_tdata));
                    mismatches++;
                end
                if (m_tlast !== want.closing)
                begin
                    $error("last_res: expected %0b, got %0b", want.closing, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== want.dropped)
                begin
                    $error("dropped: expected %0b, got %0b", want.dropped, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_single();
        test_equal_values();
        wait_all_sorted();
        test_overflow();
        test_single();
        wait_all_sorted();
        test_backpressure();
        wait_all_sorted();
        test_random(20);
        no_idle = 1'b1;
        test_random(12);
        wait_all_sorted();

        // Allow for any stray result after the last expected one.
        repeat (40) @(posedge clk);
        if (pending_sorted.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_sorted.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
rtl/mihs_pkg.sv
rtl/mihs_ram.sv
rtl/mihs_ctrl.sv
rtl/merge_insertion_hybrid_sort.sv
tb/testbench.sv
